/* rtl/qmn_pkg.sv */
`default_nettype none
package qmn_pkg;

  localparam int unsigned MagW   = 31;
  localparam int unsigned NormW  = 64;
  localparam int unsigned RootW  = 32;
  localparam int unsigned RecipW = 33;

  // Per-item data carried alongside the root and reciprocal pipelines.
  typedef struct packed {
    logic [3:0][MagW-1:0] mag;
    logic [3:0]           neg;
    logic                 zero;
  } side_t;

endpackage
`default_nettype wire

/* rtl/quaternion_multiply_normalize.sv */
`default_nettype none
// Normalized Hamilton quaternion product, Q2.14 in and out.
//
// Input channel: present both quaternions on the in_* ports and raise start.
// The item is taken at the rising edge where start is high and busy is low;
// busy is always low, so one item may enter on every clock.
// Result channel: out_valid is high for exactly one cycle per item with the
// four normalized components and out_zero_norm on the out_* ports. The
// receiver cannot stall; results must be taken in that cycle.
// Throughput: one item per cycle, fixed by the pipeline: 5 front stages
// (products, sums, normalize shift, squares, norm sum), a 32-stage square
// root, a 33-stage reciprocal divider, a scaling multiply stage and an
// output stage.
// Reset (rst_n low, synchronous) drops all items in flight; out_valid
// stays low until new items reach the end of the pipeline.
module quaternion_multiply_normalize (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] in_left_x,
  input  wire logic signed [15:0] in_left_y,
  input  wire logic signed [15:0] in_left_z,
  input  wire logic signed [15:0] in_left_w,
  input  wire logic signed [15:0] in_right_x,
  input  wire logic signed [15:0] in_right_y,
  input  wire logic signed [15:0] in_right_z,
  input  wire logic signed [15:0] in_right_w,
  output logic                    out_valid,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic signed [15:0]      out_z,
  output logic signed [15:0]      out_w,
  output logic                    out_zero_norm
);
  import qmn_pkg::*;

  assign busy = 1'b0;

  // Stage 1: all sixteen partial products.
  logic signed [31:0] pr_r [0:15];
  logic               v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
    // x term
    pr_r[0]  <= in_left_w * in_right_x;
    pr_r[1]  <= in_left_x * in_right_w;
    pr_r[2]  <= in_left_y * in_right_z;
    pr_r[3]  <= in_left_z * in_right_y;
    // y term
    pr_r[4]  <= in_left_w * in_right_y;
    pr_r[5]  <= in_left_y * in_right_w;
    pr_r[6]  <= in_left_z * in_right_x;
    pr_r[7]  <= in_left_x * in_right_z;
    // z term
    pr_r[8]  <= in_left_w * in_right_z;
    pr_r[9]  <= in_left_z * in_right_w;
    pr_r[10] <= in_left_x * in_right_y;
    pr_r[11] <= in_left_y * in_right_x;
    // w term
    pr_r[12] <= in_left_w * in_right_w;
    pr_r[13] <= in_left_x * in_right_x;
    pr_r[14] <= in_left_y * in_right_y;
    pr_r[15] <= in_left_z * in_right_z;
  end

  // Stage 2: exact components, split into sign and magnitude.
  logic signed [33:0] comp [0:3];
  logic [32:0]        abs2_r [0:3];
  logic [3:0]         neg2_r;
  logic               v2_r;

  always_comb begin
    comp[0] = 34'(pr_r[0]) + 34'(pr_r[1]) + 34'(pr_r[2]) - 34'(pr_r[3]);
    comp[1] = 34'(pr_r[4]) + 34'(pr_r[5]) + 34'(pr_r[6]) - 34'(pr_r[7]);
    comp[2] = 34'(pr_r[8]) + 34'(pr_r[9]) + 34'(pr_r[10]) - 34'(pr_r[11]);
    comp[3] = 34'(pr_r[12]) - 34'(pr_r[13]) - 34'(pr_r[14]) - 34'(pr_r[15]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    for (int i = 0; i < 4; i++) begin
      neg2_r[i] <= comp[i][33];
      abs2_r[i] <= comp[i][33] ? 33'(-comp[i]) : comp[i][32:0];
    end
  end

  // Stage 3: block exponent, bring the largest magnitude to bit 30.
  logic [32:0] orv;
  logic [5:0]  lead;
  side_t       side3_r;
  logic        v3_r;

  always_comb begin
    orv  = abs2_r[0] | abs2_r[1] | abs2_r[2] | abs2_r[3];
    lead = '0;
    for (int b = 0; b < 33; b++) begin
      if (orv[b]) lead = 6'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    for (int i = 0; i < 4; i++) begin
      if (lead > 6'd30) begin
        side3_r.mag[i] <= MagW'(abs2_r[i] >> (lead - 6'd30));
      end else begin
        side3_r.mag[i] <= MagW'(abs2_r[i] << (6'd30 - lead));
      end
    end
    side3_r.neg  <= neg2_r;
    side3_r.zero <= (orv == '0);
  end

  // Stage 4: squares.
  logic [61:0] sq4_r [0:3];
  side_t       side4_r;
  logic        v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    for (int i = 0; i < 4; i++) begin
      sq4_r[i] <= {31'd0, side3_r.mag[i]} * {31'd0, side3_r.mag[i]};
    end
    side4_r <= side3_r;
  end

  // Stage 5: squared norm, below 2^64.
  logic [NormW-1:0] n5_r;
  side_t            side5_r;
  logic             v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    n5_r    <= NormW'({2'b00, sq4_r[0]} + {2'b00, sq4_r[1]} +
                      {2'b00, sq4_r[2]} + {2'b00, sq4_r[3]});
    side5_r <= side4_r;
  end

  // Square root, then reciprocal 2^62 / root.
  logic             vs;
  logic [RootW-1:0] root;
  side_t            side_s;
  logic              vr;
  logic [RecipW-1:0] recip;
  side_t             side_q;

  qmn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v5_r),
    .in_n     (n5_r),
    .in_side  (side5_r),
    .out_vld  (vs),
    .out_root (root),
    .out_side (side_s)
  );

  qmn_recip u_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (vs),
    .in_root   (root),
    .in_side   (side_s),
    .out_vld   (vr),
    .out_recip (recip),
    .out_side  (side_q)
  );

  // Scale stage: magnitude times reciprocal, below 2^63.
  logic [63:0] sc_r [0:3];
  logic [3:0]  negm_r;
  logic        zerom_r;
  logic        vm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else begin
      vm_r <= vr;
    end
    for (int i = 0; i < 4; i++) begin
      sc_r[i] <= {33'd0, side_q.mag[i]} * {31'd0, recip};
    end
    negm_r  <= side_q.neg;
    zerom_r <= side_q.zero;
  end

  // Output stage: round on the magnitude, saturate, apply the sign.
  logic [64:0] rsum [0:3];
  logic [16:0] mag  [0:3];
  logic [15:0] res  [0:3];
  logic [15:0] out_r [0:3];
  logic        zero_r;
  logic        vo_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rsum[i] = {1'b0, sc_r[i]} + (65'd1 << 47);
      mag[i]  = rsum[i][64:48];
      if (negm_r[i]) begin
        res[i] = (mag[i] > 17'd32768) ? 16'h8000 : 16'(17'd0 - mag[i]);
      end else begin
        res[i] = (mag[i] > 17'd32767) ? 16'h7fff : mag[i][15:0];
      end
      if (zerom_r) res[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= vm_r;
    end
    for (int i = 0; i < 4; i++) begin
      out_r[i] <= res[i];
    end
    zero_r <= zerom_r;
  end

  assign out_valid     = vo_r;
  assign out_x         = out_r[0];
  assign out_y         = out_r[1];
  assign out_z         = out_r[2];
  assign out_w         = out_r[3];
  assign out_zero_norm = zero_r;

  a_zero_out : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_norm) |->
      (out_x == '0 && out_y == '0 && out_z == '0 && out_w == '0))
    else $error("zero-norm item with nonzero components");
  a_unit_out : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_zero_norm) |->
      !(out_x == '0 && out_y == '0 && out_z == '0 && out_w == '0))
    else $error("normalized item came out all zero");
  a_reset_flush : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule
`default_nettype wire

/* rtl/qmn_isqrt.sv */
`default_nettype none
module qmn_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_vld,
  input  wire logic [63:0]               in_n,
  input  wire qmn_pkg::side_t            in_side,
  output logic                           out_vld,
  output logic [31:0]                    out_root,
  output qmn_pkg::side_t                 out_side
);
  import qmn_pkg::*;

  // One root bit per stage, remainder method.
  logic [33:0] rem_r  [0:32];
  logic [31:0] root_r [0:32];
  logic [63:0] n_r    [0:32];
  side_t       side_r [0:32];
  logic        vld_r  [0:32];

  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign n_r[0]    = in_n;
  assign side_r[0] = in_side;
  assign vld_r[0]  = in_vld;

  for (genvar g = 0; g < 32; g++) begin : g_step
    localparam int unsigned K = 31 - g;
    logic [35:0] rem_sh;
    logic [35:0] test;
    always_comb begin
      rem_sh = {rem_r[g], n_r[g][2*K+1 -: 2]};
      test   = {2'b00, root_r[g], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
      if (rem_sh >= test) begin
        rem_r[g+1]  <= 34'(rem_sh - test);
        root_r[g+1] <= {root_r[g][30:0], 1'b1};
      end else begin
        rem_r[g+1]  <= rem_sh[33:0];
        root_r[g+1] <= {root_r[g][30:0], 1'b0};
      end
      n_r[g+1]    <= n_r[g];
      side_r[g+1] <= side_r[g];
    end
  end

  assign out_vld  = vld_r[32];
  assign out_root = root_r[32];
  assign out_side = side_r[32];

  logic [64:0] root_sq;
  logic [64:0] root_p1_sq;
  assign root_sq    = 65'({33'd0, root_r[32]} * {33'd0, root_r[32]});
  assign root_p1_sq = 65'(({33'd0, root_r[32]} + 65'd1) * ({33'd0, root_r[32]} + 65'd1));

  a_root_low : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> root_sq <= {1'b0, n_r[32]})
    else $error("root squared exceeds radicand");
  a_root_high : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> root_p1_sq > {1'b0, n_r[32]})
    else $error("root too small");

endmodule
`default_nettype wire

/* rtl/qmn_recip.sv */
`default_nettype none
module qmn_recip (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_vld,
  input  wire logic [31:0]               in_root,
  input  wire qmn_pkg::side_t            in_side,
  output logic                           out_vld,
  output logic [32:0]                    out_recip,
  output qmn_pkg::side_t                 out_side
);
  import qmn_pkg::*;

  // Restoring division of 2^62 by the root, one quotient bit per stage.
  // For a nonzero norm the root is >= 2^30, so all quotient bits above bit 32 are zero.
  logic [32:0] rem_r  [0:33];
  logic [32:0] q_r    [0:33];
  logic [31:0] d_r    [0:33];
  side_t       side_r [0:33];
  logic        vld_r  [0:33];

  assign rem_r[0]  = 33'h0_2000_0000;
  assign q_r[0]    = '0;
  assign d_r[0]    = in_root;
  assign side_r[0] = in_side;
  assign vld_r[0]  = in_vld;

  for (genvar g = 0; g < 33; g++) begin : g_step
    logic [32:0] rem_sh;
    assign rem_sh = {rem_r[g][31:0], 1'b0};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
      if (rem_sh >= {1'b0, d_r[g]}) begin
        rem_r[g+1] <= rem_sh - {1'b0, d_r[g]};
        q_r[g+1]   <= {q_r[g][31:0], 1'b1};
      end else begin
        rem_r[g+1] <= rem_sh;
        q_r[g+1]   <= {q_r[g][31:0], 1'b0};
      end
      d_r[g+1]    <= d_r[g];
      side_r[g+1] <= side_r[g];
    end
  end

  assign out_vld   = vld_r[33];
  assign out_recip = q_r[33];
  assign out_side  = side_r[33];

  logic [65:0] qd;
  assign qd = 66'({33'd0, q_r[33]} * {34'd0, d_r[33]});

  a_quot_low : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && d_r[33] != '0) |-> qd <= (66'd1 << 62))
    else $error("quotient too large");
  a_quot_high : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && d_r[33] != '0) |-> (qd + {34'd0, d_r[33]}) > (66'd1 << 62))
    else $error("quotient too small");

endmodule
`default_nettype wire
